// ----- rtl/core/tam_pkg.sv -----
// Shared widths, latencies, types and the Q2.28 to Q1.14 rounding function
// for the attitude matrix pipeline. No dependencies.
package tam_pkg;

	localparam int IW       = 24;
	localparam int VW       = 31;
	localparam int MW       = 30;
	localparam int SW       = 62;
	localparam int KW       = 6;
	localparam int LW       = SW / 2;
	localparam int QW       = 16;
	localparam int PW       = 32;
	localparam int FRAC     = 14;
	localparam int QB       = FRAC + 1;
	localparam int NUM_W    = LW + QB;
	localparam int ONE_Q14  = 1 << FRAC;
	localparam int XW       = 15;
	localparam int NORM_N   = 6;
	localparam int SQ_N     = SW / 2;
	localparam int UNIT_LAT = 2 + NORM_N + SQ_N + 1 + QB + 1;
	localparam int CROSS_LAT = 2;
	localparam int MAT_LAT  = 3;
	localparam int L1       = CROSS_LAT + UNIT_LAT;
	localparam int LAT      = 1 + UNIT_LAT + L1 + CROSS_LAT + 1 + MAT_LAT;

	typedef logic signed [VW-1:0] vin_t;
	typedef logic signed [QW-1:0] q14_t;
	typedef logic signed [PW-1:0] q28_t;

	typedef enum logic [1:0] {
		REG_SUN_MIN = 2'd0,
		REG_FLD_MIN = 2'd1,
		REG_XMIN    = 2'd2
	} reg_idx_t;

	function automatic q14_t round_q28(input q28_t x);
		logic [PW-1:0] m;
		logic [PW-FRAC-1:0] r;
		logic [QW-1:0] c;
		m = x[PW-1] ? PW'(-x) : PW'(x);
		r = (PW-FRAC)'((m + PW'(1 << (FRAC - 1))) >> FRAC);
		c = (r > (PW-FRAC)'(ONE_Q14)) ? QW'(ONE_Q14) : QW'(r);
		return x[PW-1] ? -c : c;
	endfunction

endpackage

// ----- rtl/core/tam_unitize.sv -----
// Unit vector pipeline: sum of squares, threshold test, normalizing shift,
// digit-serial square root and restoring division per stage. Uses tam_pkg.
module tam_unitize (
	input  logic                    clk,
	input  logic                    en,
	input  tam_pkg::vin_t           vec [3],
	input  logic [tam_pkg::SW-1:0]  thr,
	output tam_pkg::q14_t           unit_vec [3],
	output logic                    ok
);

	typedef struct packed {
		logic [2:0][tam_pkg::MW-1:0] mag;
		logic [2:0]                  neg;
		logic                        ok;
	} carry_t;

	logic [2:0][tam_pkg::MW-1:0] mag_c;
	logic [2:0]                  neg_c;
	logic [2*tam_pkg::MW-1:0]    sq_s1 [3];
	carry_t                      cr_s1;
	carry_t                      cr_s2;
	logic [tam_pkg::SW-1:0]      sum_c;
	logic [tam_pkg::SW-1:0]      sum_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = vec[i][tam_pkg::VW-1];
			mag_c[i] = neg_c[i] ? tam_pkg::MW'(-vec[i]) : tam_pkg::MW'(vec[i]);
		end
		sum_c = tam_pkg::SW'(sq_s1[0]) + tam_pkg::SW'(sq_s1[1]) + tam_pkg::SW'(sq_s1[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= {{tam_pkg::MW{1'b0}}, mag_c[i]} * {{tam_pkg::MW{1'b0}}, mag_c[i]};
			end
			cr_s1.mag <= mag_c;
			cr_s1.neg <= neg_c;
			cr_s1.ok  <= 1'b0;
			sum_s2    <= sum_c;
			cr_s2.mag <= cr_s1.mag;
			cr_s2.neg <= cr_s1.neg;
			cr_s2.ok  <= (sum_c != '0) && (sum_c >= thr);
		end
	end

	// normalize: shift by powers of four until the top pair is nonzero
	logic [tam_pkg::SW-1:0] nrm_s [tam_pkg::NORM_N];
	logic [tam_pkg::KW-1:0] nk_s  [tam_pkg::NORM_N];
	carry_t                 ncr_s [tam_pkg::NORM_N];

	for (genvar n = 0; n < tam_pkg::NORM_N; n++) begin : g_norm
		localparam int NJ   = (n == tam_pkg::NORM_N - 1) ? 1 : (16 >> n);
		localparam int TOPB = (n == tam_pkg::NORM_N - 1) ? 2 : 2 * NJ + 2;
		logic [tam_pkg::SW-1:0] s_in;
		logic [tam_pkg::KW-1:0] k_in;
		carry_t                 c_in;
		if (n == 0) begin : g_first
			assign s_in = sum_s2;
			assign k_in = '0;
			assign c_in = cr_s2;
		end else begin : g_next
			assign s_in = nrm_s[n-1];
			assign k_in = nk_s[n-1];
			assign c_in = ncr_s[n-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (s_in[tam_pkg::SW-1 -: TOPB] == '0) begin
					nrm_s[n] <= s_in << (2 * NJ);
					nk_s[n]  <= k_in + tam_pkg::KW'(NJ);
				end else begin
					nrm_s[n] <= s_in;
					nk_s[n]  <= k_in;
				end
				ncr_s[n] <= c_in;
			end
		end
	end

	// square root, one result bit per stage
	logic [tam_pkg::SW-1:0] sx_s  [tam_pkg::SQ_N];
	logic [tam_pkg::SW-1:0] sr_s  [tam_pkg::SQ_N];
	logic [tam_pkg::KW-1:0] sk_s  [tam_pkg::SQ_N];
	carry_t                 scr_s [tam_pkg::SQ_N];

	for (genvar i = 0; i < tam_pkg::SQ_N; i++) begin : g_sqrt
		localparam logic [tam_pkg::SW-1:0] BIT =
			{{(tam_pkg::SW-1){1'b0}}, 1'b1} << (tam_pkg::SW - 2 - 2 * i);
		logic [tam_pkg::SW-1:0] x_in;
		logic [tam_pkg::SW-1:0] r_in;
		logic [tam_pkg::KW-1:0] k_in;
		carry_t                 c_in;
		logic [tam_pkg::SW:0]   trial;
		if (i == 0) begin : g_first
			assign x_in = nrm_s[tam_pkg::NORM_N-1];
			assign r_in = '0;
			assign k_in = nk_s[tam_pkg::NORM_N-1];
			assign c_in = ncr_s[tam_pkg::NORM_N-1];
		end else begin : g_next
			assign x_in = sx_s[i-1];
			assign r_in = sr_s[i-1];
			assign k_in = sk_s[i-1];
			assign c_in = scr_s[i-1];
		end
		assign trial = {1'b0, r_in} + {1'b0, BIT};
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, x_in} >= trial) begin
					sx_s[i] <= x_in - trial[tam_pkg::SW-1:0];
					sr_s[i] <= (r_in >> 1) + BIT;
				end else begin
					sx_s[i] <= x_in;
					sr_s[i] <= r_in >> 1;
				end
				sk_s[i]  <= k_in;
				scr_s[i] <= c_in;
			end
		end
	end

	// scale numerators and add half the divisor for rounding
	logic [tam_pkg::LW-1:0]    len_c;
	logic [tam_pkg::NUM_W-1:0] num_c [3];
	logic [tam_pkg::NUM_W-1:0] pr_rem_s [3];
	logic [tam_pkg::LW-1:0]    pr_len_s;
	carry_t                    pr_cr_s;

	always_comb begin
		len_c = sr_s[tam_pkg::SQ_N-1][tam_pkg::LW-1:0];
		for (int i = 0; i < 3; i++) begin
			num_c[i] = ((tam_pkg::NUM_W'(scr_s[tam_pkg::SQ_N-1].mag[i])
				<< sk_s[tam_pkg::SQ_N-1]) << tam_pkg::FRAC)
				+ tam_pkg::NUM_W'(len_c >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_rem_s <= num_c;
			pr_len_s <= len_c;
			pr_cr_s  <= scr_s[tam_pkg::SQ_N-1];
		end
	end

	// restoring division, one quotient bit per stage
	logic [tam_pkg::NUM_W-1:0] dr_s [tam_pkg::QB][3];
	logic [tam_pkg::QB-1:0]    dq_s [tam_pkg::QB][3];
	logic [tam_pkg::LW-1:0]    dl_s [tam_pkg::QB];
	carry_t                    dc_s [tam_pkg::QB];

	for (genvar d = 0; d < tam_pkg::QB; d++) begin : g_div
		localparam int J = tam_pkg::QB - 1 - d;
		logic [tam_pkg::NUM_W-1:0] r_in [3];
		logic [tam_pkg::QB-1:0]    q_in [3];
		logic [tam_pkg::LW-1:0]    l_in;
		carry_t                    c_in;
		logic [tam_pkg::NUM_W:0]   dv;
		if (d == 0) begin : g_first
			assign r_in = pr_rem_s;
			assign q_in = '{default: '0};
			assign l_in = pr_len_s;
			assign c_in = pr_cr_s;
		end else begin : g_next
			assign r_in = dr_s[d-1];
			assign q_in = dq_s[d-1];
			assign l_in = dl_s[d-1];
			assign c_in = dc_s[d-1];
		end
		assign dv = (tam_pkg::NUM_W + 1)'(l_in) << J;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if ({1'b0, r_in[i]} >= dv) begin
						dr_s[d][i] <= r_in[i] - dv[tam_pkg::NUM_W-1:0];
						dq_s[d][i] <= q_in[i] | (tam_pkg::QB'(1) << J);
					end else begin
						dr_s[d][i] <= r_in[i];
						dq_s[d][i] <= q_in[i];
					end
				end
				dl_s[d] <= l_in;
				dc_s[d] <= c_in;
			end
		end
	end

	tam_pkg::q14_t          uvec_q [3];
	logic                   uok_q;
	logic [tam_pkg::QB-1:0] qv_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv_c[i] = (dq_s[tam_pkg::QB-1][i] > tam_pkg::QB'(tam_pkg::ONE_Q14)) ?
				tam_pkg::QB'(tam_pkg::ONE_Q14) : dq_s[tam_pkg::QB-1][i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				uvec_q[i] <= dc_s[tam_pkg::QB-1].neg[i] ?
					-tam_pkg::QW'(qv_c[i]) : tam_pkg::QW'(qv_c[i]);
			end
			uok_q <= dc_s[tam_pkg::QB-1].ok;
		end
	end

	assign unit_vec = uvec_q;
	assign ok       = uok_q;

endmodule

// ----- rtl/core/tam_cross.sv -----
// Two-stage cross product of two Q1.14 vectors, exact Q2.28 result.
// Uses tam_pkg.
module tam_cross (
	input  logic          clk,
	input  logic          en,
	input  tam_pkg::q14_t a [3],
	input  tam_pkg::q14_t b [3],
	output tam_pkg::vin_t c [3]
);

	tam_pkg::q28_t prod_c [6];
	tam_pkg::q28_t p_s1 [6];
	tam_pkg::vin_t c_s2 [3];

	always_comb begin
		prod_c[0] = a[1] * b[2];
		prod_c[1] = a[2] * b[1];
		prod_c[2] = a[2] * b[0];
		prod_c[3] = a[0] * b[2];
		prod_c[4] = a[0] * b[1];
		prod_c[5] = a[1] * b[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= prod_c;
			c_s2[0] <= tam_pkg::VW'(p_s1[0] - p_s1[1]);
			c_s2[1] <= tam_pkg::VW'(p_s1[2] - p_s1[3]);
			c_s2[2] <= tam_pkg::VW'(p_s1[4] - p_s1[5]);
		end
	end

	assign c = c_s2;

endmodule

// ----- rtl/core/tam_matrix.sv -----
// Rotation matrix as the sum of three outer products: multiply, add, round, or zero when ok_in is low.
// Uses tam_pkg.
module tam_matrix (
	input  logic          clk,
	input  logic          en,
	input  tam_pkg::q14_t nb [3][3],
	input  tam_pkg::q14_t nn [3][3],
	input  logic          ok_in,
	output tam_pkg::q14_t rot [9],
	output logic          sol
);

	tam_pkg::q28_t prod_c [27];
	tam_pkg::q28_t pr_s1 [27];
	tam_pkg::q28_t acc_s2 [9];
	logic          ok_s1;
	logic          ok_s2;
	tam_pkg::q14_t rot_s3 [9];
	logic          sol_s3;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				for (int t = 0; t < 3; t++) begin
					prod_c[(r * 3 + c) * 3 + t] = nb[t][r] * nn[t][c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1 <= prod_c;
			ok_s1 <= ok_in;
			for (int e = 0; e < 9; e++) begin
				acc_s2[e] <= pr_s1[e * 3] + pr_s1[e * 3 + 1] + pr_s1[e * 3 + 2];
				rot_s3[e] <= ok_s2 ? tam_pkg::round_q28(acc_s2[e]) : '0;
			end
			ok_s2  <= ok_s1;
			sol_s3 <= ok_s2;
		end
	end

	assign rot = rot_s3;
	assign sol = sol_s3;

endmodule

// ----- rtl/core/triad_attitude_matrix.sv -----
// Top level of the attitude matrix pipeline: input register, unit vector and
// cross product units, triad rounding, matrix stage. Uses tam_pkg and all tam_ modules.
//
// One observation set (sun and field, body and reference) enters as a word on
// the obs channel when obs_valid is high and obs_stall low. The result word
// (nine Q1.14 entries and solution_valid) leaves on the rot channel when
// rot_valid is high and rot_stall low. A failed norm test gives a zero matrix
// with solution_valid low.
// The pipeline runs through the input register, two unit vector passes of 56
// stages each (square root and division one bit per stage), two cross product
// passes, a rounding stage and the three matrix stages.
// One word is accepted per cycle while the output is not stalled. A stalled
// output word holds the whole pipeline, and obs_stall follows it in the same
// cycle; nothing is lost. Reset clears the valid line and loads the register
// defaults (sun and field minimum 1, cross minimum 16). Registers are written
// on the cfg channel, always ready; write them only while the pipeline is empty.
module triad_attitude_matrix (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    obs_valid,
	output logic                    obs_stall,
	input  logic signed [23:0]      sun_body_x,
	input  logic signed [23:0]      sun_body_y,
	input  logic signed [23:0]      sun_body_z,
	input  logic signed [23:0]      mag_body_x,
	input  logic signed [23:0]      mag_body_y,
	input  logic signed [23:0]      mag_body_z,
	input  logic signed [23:0]      sun_ref_x,
	input  logic signed [23:0]      sun_ref_y,
	input  logic signed [23:0]      sun_ref_z,
	input  logic signed [23:0]      mag_ref_x,
	input  logic signed [23:0]      mag_ref_y,
	input  logic signed [23:0]      mag_ref_z,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [23:0]             cfg_data,
	output logic                    rot_valid,
	input  logic                    rot_stall,
	output logic signed [15:0]      rot_00,
	output logic signed [15:0]      rot_01,
	output logic signed [15:0]      rot_02,
	output logic signed [15:0]      rot_10,
	output logic signed [15:0]      rot_11,
	output logic signed [15:0]      rot_12,
	output logic signed [15:0]      rot_20,
	output logic signed [15:0]      rot_21,
	output logic signed [15:0]      rot_22,
	output logic                    solution_valid
);

	typedef struct packed {
		logic [2:0][tam_pkg::QW-1:0] b;
		logic [2:0][tam_pkg::QW-1:0] n;
		logic                        ok;
	} tri_t;

	typedef struct packed {
		logic [2:0][tam_pkg::QW-1:0] b1;
		logic [2:0][tam_pkg::QW-1:0] n1;
		logic [2:0][tam_pkg::QW-1:0] b2;
		logic [2:0][tam_pkg::QW-1:0] n2;
		logic                        ok;
	} quad_t;

	logic en;
	assign en        = !(rot_valid && rot_stall);
	assign obs_stall = !en;
	assign cfg_ready = 1'b1;

	// registers and squared thresholds
	logic [tam_pkg::IW-1:0]   sun_min_q;
	logic [tam_pkg::IW-1:0]   fld_min_q;
	logic [tam_pkg::XW-1:0]   xmin_q;
	logic [tam_pkg::SW-1:0]   sun_thr_q;
	logic [tam_pkg::SW-1:0]   fld_thr_q;
	logic [tam_pkg::SW-1:0]   x_thr_q;
	logic [2*tam_pkg::IW-1:0] sun_sq_c;
	logic [2*tam_pkg::IW-1:0] fld_sq_c;
	logic [2*tam_pkg::XW-1:0] x_sq_c;

	assign sun_sq_c = sun_min_q * sun_min_q;
	assign fld_sq_c = fld_min_q * fld_min_q;
	assign x_sq_c   = xmin_q * xmin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sun_min_q <= tam_pkg::IW'(1);
			fld_min_q <= tam_pkg::IW'(1);
			xmin_q    <= tam_pkg::XW'(16);
			sun_thr_q <= tam_pkg::SW'(1);
			fld_thr_q <= tam_pkg::SW'(1);
			x_thr_q   <= tam_pkg::SW'(256) << (2 * tam_pkg::FRAC);
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (tam_pkg::reg_idx_t'(cfg_index))
					tam_pkg::REG_SUN_MIN: sun_min_q <= cfg_data;
					tam_pkg::REG_FLD_MIN: fld_min_q <= cfg_data;
					tam_pkg::REG_XMIN:    xmin_q    <= cfg_data[tam_pkg::XW-1:0];
					default: ;
				endcase
			end
			sun_thr_q <= tam_pkg::SW'(sun_sq_c);
			fld_thr_q <= tam_pkg::SW'(fld_sq_c);
			x_thr_q   <= tam_pkg::SW'(x_sq_c) << (2 * tam_pkg::FRAC);
		end
	end

	// valid line
	logic vld_s [tam_pkg::LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tam_pkg::LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= obs_valid;
			for (int i = 1; i < tam_pkg::LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	assign rot_valid = vld_s[tam_pkg::LAT-1];

	// input register
	tam_pkg::vin_t sb_s1 [3];
	tam_pkg::vin_t mb_s1 [3];
	tam_pkg::vin_t sn_s1 [3];
	tam_pkg::vin_t mn_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1[0] <= tam_pkg::VW'(sun_body_x);
			sb_s1[1] <= tam_pkg::VW'(sun_body_y);
			sb_s1[2] <= tam_pkg::VW'(sun_body_z);
			mb_s1[0] <= tam_pkg::VW'(mag_body_x);
			mb_s1[1] <= tam_pkg::VW'(mag_body_y);
			mb_s1[2] <= tam_pkg::VW'(mag_body_z);
			sn_s1[0] <= tam_pkg::VW'(sun_ref_x);
			sn_s1[1] <= tam_pkg::VW'(sun_ref_y);
			sn_s1[2] <= tam_pkg::VW'(sun_ref_z);
			mn_s1[0] <= tam_pkg::VW'(mag_ref_x);
			mn_s1[1] <= tam_pkg::VW'(mag_ref_y);
			mn_s1[2] <= tam_pkg::VW'(mag_ref_z);
		end
	end

	// unit vectors of the four measurements
	tam_pkg::q14_t usb [3];
	tam_pkg::q14_t umb [3];
	tam_pkg::q14_t usn [3];
	tam_pkg::q14_t umn [3];
	logic          ok_sb, ok_mb, ok_sn, ok_mn;

	tam_unitize u_sb (.clk(clk), .en(en), .vec(sb_s1), .thr(sun_thr_q),
		.unit_vec(usb), .ok(ok_sb));
	tam_unitize u_mb (.clk(clk), .en(en), .vec(mb_s1), .thr(fld_thr_q),
		.unit_vec(umb), .ok(ok_mb));
	tam_unitize u_sn (.clk(clk), .en(en), .vec(sn_s1), .thr(sun_thr_q),
		.unit_vec(usn), .ok(ok_sn));
	tam_unitize u_mn (.clk(clk), .en(en), .vec(mn_s1), .thr(fld_thr_q),
		.unit_vec(umn), .ok(ok_mn));

	// sun x field in each frame
	tam_pkg::vin_t cb [3];
	tam_pkg::vin_t cn [3];

	tam_cross u_cb (.clk(clk), .en(en), .a(usb), .b(umb), .c(cb));
	tam_cross u_cn (.clk(clk), .en(en), .a(usn), .b(umn), .c(cn));

	tam_pkg::q14_t n2b [3];
	tam_pkg::q14_t n2n [3];
	logic          ok_cb, ok_cn;

	tam_unitize u_n2b (.clk(clk), .en(en), .vec(cb), .thr(x_thr_q),
		.unit_vec(n2b), .ok(ok_cb));
	tam_unitize u_n2n (.clk(clk), .en(en), .vec(cn), .thr(x_thr_q),
		.unit_vec(n2n), .ok(ok_cn));

	// carry the first triad vectors alongside the cross and second unit passes
	tri_t tri_c;
	tri_t ln1_s2 [tam_pkg::L1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tri_c.b[i] = usb[i];
			tri_c.n[i] = usn[i];
		end
		tri_c.ok = ok_sb && ok_mb && ok_sn && ok_mn;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ln1_s2[0] <= tri_c;
			for (int i = 1; i < tam_pkg::L1; i++) begin
				ln1_s2[i] <= ln1_s2[i-1];
			end
		end
	end

	// third triad vector n1 x n2
	tam_pkg::q14_t n1b [3];
	tam_pkg::q14_t n1n [3];
	tam_pkg::vin_t tb [3];
	tam_pkg::vin_t tn [3];
	quad_t         quad_c;
	quad_t         ln2_s3 [tam_pkg::CROSS_LAT];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n1b[i]        = $signed(ln1_s2[tam_pkg::L1-1].b[i]);
			n1n[i]        = $signed(ln1_s2[tam_pkg::L1-1].n[i]);
			quad_c.b1[i]  = ln1_s2[tam_pkg::L1-1].b[i];
			quad_c.n1[i]  = ln1_s2[tam_pkg::L1-1].n[i];
			quad_c.b2[i]  = n2b[i];
			quad_c.n2[i]  = n2n[i];
		end
		quad_c.ok = ln1_s2[tam_pkg::L1-1].ok && ok_cb && ok_cn;
	end

	tam_cross u_tb (.clk(clk), .en(en), .a(n1b), .b(n2b), .c(tb));
	tam_cross u_tn (.clk(clk), .en(en), .a(n1n), .b(n2n), .c(tn));

	always_ff @(posedge clk) begin
		if (en) begin
			ln2_s3[0] <= quad_c;
			for (int i = 1; i < tam_pkg::CROSS_LAT; i++) begin
				ln2_s3[i] <= ln2_s3[i-1];
			end
		end
	end

	tam_pkg::q14_t n3b_s4 [3];
	tam_pkg::q14_t n3n_s4 [3];
	quad_t         q_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n3b_s4[i] <= tam_pkg::round_q28(tam_pkg::PW'(tb[i]));
				n3n_s4[i] <= tam_pkg::round_q28(tam_pkg::PW'(tn[i]));
			end
			q_s4 <= ln2_s3[tam_pkg::CROSS_LAT-1];
		end
	end

	// matrix
	tam_pkg::q14_t nb [3][3];
	tam_pkg::q14_t nn [3][3];
	tam_pkg::q14_t rot [9];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nb[0][i] = $signed(q_s4.b1[i]);
			nb[1][i] = $signed(q_s4.b2[i]);
			nb[2][i] = n3b_s4[i];
			nn[0][i] = $signed(q_s4.n1[i]);
			nn[1][i] = $signed(q_s4.n2[i]);
			nn[2][i] = n3n_s4[i];
		end
	end

	tam_matrix u_mat (.clk(clk), .en(en), .nb(nb), .nn(nn), .ok_in(q_s4.ok),
		.rot(rot), .sol(solution_valid));

	assign rot_00 = rot[0];
	assign rot_01 = rot[1];
	assign rot_02 = rot[2];
	assign rot_10 = rot[3];
	assign rot_11 = rot[4];
	assign rot_12 = rot[5];
	assign rot_20 = rot[6];
	assign rot_21 = rot[7];
	assign rot_22 = rot[8];

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_valid && !solution_valid) |->
		(rot_00 == 16'sd0 && rot_01 == 16'sd0 && rot_02 == 16'sd0 &&
		 rot_10 == 16'sd0 && rot_11 == 16'sd0 && rot_12 == 16'sd0 &&
		 rot_20 == 16'sd0 && rot_21 == 16'sd0 && rot_22 == 16'sd0))
		else $error("failed solution carries a nonzero matrix");

	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_valid && solution_valid) |->
		(rot_00 >= -16'sd16384 && rot_00 <= 16'sd16384 &&
		 rot_11 >= -16'sd16384 && rot_11 <= 16'sd16384 &&
		 rot_22 >= -16'sd16384 && rot_22 <= 16'sd16384))
		else $error("matrix diagonal outside unit range");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rot_valid && rot_stall) |=> (rot_valid && $stable(solution_valid)))
		else $error("stalled result word changed");

endmodule
